// ===== sv/cpl_pkg.sv =====
`timescale 1ns / 1ps
package cpl_pkg;

   typedef enum logic [3:0] {
      M_IDLE      = 4'd0,
      M_IDENT     = 4'd1,
      M_ZERO      = 4'd2,
      M_DEC       = 4'd3,
      M_EXPMARK   = 4'd4,
      M_EXPDIG    = 4'd5,
      M_HEX       = 4'd6,
      M_SUFFIX    = 4'd7,
      M_DOT       = 4'd8,
      M_SLASH     = 4'd9,
      M_PAIR      = 4'd10,
      M_STR       = 4'd11,
      M_STRESC    = 4'd12,
      M_BLOCK     = 4'd13,
      M_BLOCKSTAR = 4'd14,
      M_LINE      = 4'd15
   } mode_type;

   localparam logic [2:0] KIND_IDENT = 3'd0;
   localparam logic [2:0] KIND_NUM   = 3'd1;
   localparam logic [2:0] KIND_STR   = 3'd2;
   localparam logic [2:0] KIND_CHAR  = 3'd3;
   localparam logic [2:0] KIND_PUNCT = 3'd4;

   // one result transaction
   typedef struct packed {
      logic [7:0] text_byte;
      logic [2:0] token_kind;
      logic [8:0] punct_code;
      logic       token_first;
      logic       token_last;
      logic       run_last;
      logic       source_done;
   } result_type;

   // up to two results caused by one source byte
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } pair_type;

endpackage

// ===== sv/cpl_front.sv =====
`timescale 1ns / 1ps
module cpl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        c,
   input  logic              src_end,
   output cpl_pkg::pair_type out
);

   cpl_pkg::mode_type mode_ff, mode_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic       quote_ff, quote_in;
   logic       held_first_ff, held_first_in;
   logic [8:0] held_code_ff, held_code_in;

   function automatic logic is_digit(input logic [7:0] x);
      return x >= "0" && x <= "9";
   endfunction
   function automatic logic is_wstart(input logic [7:0] x);
      return x == "_" || x == "$" || (x >= "A" && x <= "Z") || (x >= "a" && x <= "z");
   endfunction
   function automatic logic is_hex(input logic [7:0] x);
      return is_digit(x) || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
   endfunction
   function automatic logic is_suf(input logic [7:0] x);
      return x == "u" || x == "U" || x == "l" || x == "L";
   endfunction
   function automatic logic is_space(input logic [7:0] x);
      return x == 8'd32 || x == 8'd9 || x == 8'd13 || x == 8'd12 || x == 8'd11
             || x == 8'd10;
   endfunction
   function automatic logic is_lead(input logic [7:0] x);
      return x == "#" || x == "&" || x == "|" || x == "=" || x == "!" || x == "<"
             || x == ">";
   endfunction
   function automatic logic [8:0] pair_code(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] r;
      r = 9'd0;
      if (a == "#" && b == "#") r = 9'd256;
      if (a == "&" && b == "&") r = 9'd257;
      if (a == "|" && b == "|") r = 9'd258;
      if (a == "=" && b == "=") r = 9'd259;
      if (a == "!" && b == "=") r = 9'd260;
      if (a == "<" && b == "=") r = 9'd261;
      if (a == ">" && b == "=") r = 9'd262;
      if (a == "<" && b == "<") r = 9'd263;
      if (a == ">" && b == ">") r = 9'd264;
      return r;
   endfunction

   // classify one byte against held state
   always_comb begin
      logic       used, stop, ext;
      logic [2:0] hk, sk;
      cpl_pkg::mode_type nm;
      logic [8:0] pc;
      cpl_pkg::result_type r;
      used = 1'b0;
      ext = 1'b0;
      nm = cpl_pkg::M_IDLE;
      stop = src_end || c == 8'd0;
      pc = pair_code(held_char_ff, c);
      sk = quote_ff ? cpl_pkg::KIND_STR : cpl_pkg::KIND_CHAR;
      if (mode_ff == cpl_pkg::M_IDENT) hk = cpl_pkg::KIND_IDENT;
      else if (mode_ff >= cpl_pkg::M_ZERO && mode_ff <= cpl_pkg::M_SUFFIX)
         hk = cpl_pkg::KIND_NUM;
      else hk = cpl_pkg::KIND_PUNCT;
      mode_in = mode_ff;
      held_char_in = held_char_ff;
      held_valid_in = held_valid_ff;
      quote_in = quote_ff;
      held_first_in = held_first_ff;
      held_code_in = held_code_ff;
      out = '0;
      r = '0;
      r.text_byte = held_char_ff;
      r.token_kind = hk;
      r.punct_code = held_code_ff;
      r.token_first = held_first_ff;
      if (take && c != 8'd0) begin
         // continue the open token or context
         case (mode_ff)
            cpl_pkg::M_IDLE: used = 1'b0;
            cpl_pkg::M_IDENT: if (is_wstart(c) || is_digit(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_IDENT;
            end
            cpl_pkg::M_ZERO, cpl_pkg::M_DEC: begin
               if (mode_ff == cpl_pkg::M_ZERO && (c == "x" || c == "X")) begin
                  ext = 1'b1; nm = cpl_pkg::M_HEX;
               end else if (is_digit(c) || c == ".") begin
                  ext = 1'b1; nm = cpl_pkg::M_DEC;
               end else if (c == "e" || c == "E") begin
                  ext = 1'b1; nm = cpl_pkg::M_EXPMARK;
               end else if (is_suf(c)) begin
                  ext = 1'b1; nm = cpl_pkg::M_SUFFIX;
               end
            end
            cpl_pkg::M_EXPMARK: if (c == "+" || c == "-" || is_digit(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_EXPDIG;
            end else if (is_suf(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_SUFFIX;
            end
            cpl_pkg::M_EXPDIG: if (is_digit(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_EXPDIG;
            end else if (is_suf(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_SUFFIX;
            end
            cpl_pkg::M_HEX: if (is_hex(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_HEX;
            end else if (is_suf(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_SUFFIX;
            end
            cpl_pkg::M_SUFFIX: if (is_suf(c)) begin
               ext = 1'b1; nm = cpl_pkg::M_SUFFIX;
            end
            cpl_pkg::M_DOT: if (is_digit(c)) begin
               // leading dot becomes a number
               ext = 1'b1; nm = cpl_pkg::M_DEC;
               r.token_kind = cpl_pkg::KIND_NUM;
               r.punct_code = 9'd0;
               r.token_first = 1'b1;
            end
            cpl_pkg::M_SLASH: if (c == "*" || c == "/") begin
               used = 1'b1;
               held_valid_in = 1'b0; held_code_in = 9'd0; held_first_in = 1'b0;
               mode_in = (c == "*") ? cpl_pkg::M_BLOCK : cpl_pkg::M_LINE;
            end
            cpl_pkg::M_PAIR: if (pc != 9'd0) begin
               used = 1'b1;
               out.valid0 = 1'b1;
               out.res0 = r;
               out.res0.token_kind = cpl_pkg::KIND_PUNCT;
               out.res0.punct_code = pc;
               out.res0.token_first = 1'b1;
               out.valid1 = 1'b1;
               out.res1.text_byte = c;
               out.res1.token_kind = cpl_pkg::KIND_PUNCT;
               out.res1.punct_code = pc;
               out.res1.token_last = 1'b1;
               held_valid_in = 1'b0; held_code_in = 9'd0; held_first_in = 1'b0;
               mode_in = cpl_pkg::M_IDLE;
            end
            cpl_pkg::M_STR: begin
               used = 1'b1;
               out.valid0 = 1'b1;
               out.res0.text_byte = c;
               out.res0.token_kind = sk;
               out.res0.token_last = (c == (quote_ff ? 8'h22 : 8'h27)) || src_end;
               if (c == (quote_ff ? 8'h22 : 8'h27)) mode_in = cpl_pkg::M_IDLE;
               else if (c == 8'h5c) mode_in = cpl_pkg::M_STRESC;
            end
            cpl_pkg::M_STRESC: begin
               used = 1'b1;
               out.valid0 = 1'b1;
               out.res0.text_byte = c;
               out.res0.token_kind = sk;
               out.res0.token_last = src_end;
               mode_in = cpl_pkg::M_STR;
            end
            cpl_pkg::M_BLOCK: begin
               used = 1'b1;
               if (c == "*") mode_in = cpl_pkg::M_BLOCKSTAR;
            end
            cpl_pkg::M_BLOCKSTAR: begin
               used = 1'b1;
               if (c == "/") mode_in = cpl_pkg::M_IDLE;
               else if (c != "*") mode_in = cpl_pkg::M_BLOCK;
            end
            cpl_pkg::M_LINE: begin
               used = 1'b1;
               if (c == 8'd10) mode_in = cpl_pkg::M_IDLE;
            end
            default: used = 1'b0;
         endcase
         if (ext) begin
            used = 1'b1;
            out.valid0 = 1'b1;
            out.res0 = r;
            held_char_in = c; held_valid_in = 1'b1; held_first_in = 1'b0;
            mode_in = nm; held_code_in = 9'd0;
         end else if (!used && mode_ff != cpl_pkg::M_IDLE) begin
            // close the held token
            out.valid0 = 1'b1;
            out.res0 = r;
            out.res0.token_last = 1'b1;
            held_valid_in = 1'b0; held_first_in = 1'b0; held_code_in = 9'd0;
            mode_in = cpl_pkg::M_IDLE;
         end
         // start something new
         if (!used && !is_space(c)) begin
            if (c == "/" || is_wstart(c) || is_digit(c) || c == "." || is_lead(c)) begin
               held_char_in = c; held_valid_in = 1'b1; held_first_in = 1'b1;
               held_code_in = 9'd0;
               if (c == "/") begin
                  mode_in = cpl_pkg::M_SLASH; held_code_in = {1'b0, c};
               end else if (is_wstart(c)) mode_in = cpl_pkg::M_IDENT;
               else if (is_digit(c))
                  mode_in = (c == "0") ? cpl_pkg::M_ZERO : cpl_pkg::M_DEC;
               else if (c == ".") begin
                  mode_in = cpl_pkg::M_DOT; held_code_in = {1'b0, c};
               end else begin
                  mode_in = cpl_pkg::M_PAIR; held_code_in = {1'b0, c};
               end
            end else begin
               out.valid1 = out.valid0;
               out.res1.text_byte = c;
               out.res1.token_first = 1'b1;
               out.res1.token_last = 1'b1;
               if (c == 8'h22 || c == 8'h27) begin
                  quote_in = (c == 8'h22);
                  out.res1.token_kind = (c == 8'h22) ? cpl_pkg::KIND_STR
                                                     : cpl_pkg::KIND_CHAR;
                  out.res1.token_last = src_end;
                  mode_in = cpl_pkg::M_STR;
               end else begin
                  out.res1.token_kind = cpl_pkg::KIND_PUNCT;
                  out.res1.punct_code = {1'b0, c};
               end
               if (!out.valid0) begin
                  out.valid0 = 1'b1;
                  out.res0 = out.res1;
                  out.res1 = '0;
               end
            end
         end
      end
      // end of source flushes the held byte
      if (take && stop) begin
         if (held_valid_in) begin
            if (!out.valid0) begin
               out.valid0 = 1'b1;
               out.res0 = r;
               out.res0.text_byte = held_char_in;
               out.res0.token_kind = (mode_in == cpl_pkg::M_IDENT) ? cpl_pkg::KIND_IDENT :
                  (mode_in >= cpl_pkg::M_ZERO && mode_in <= cpl_pkg::M_SUFFIX) ?
                  cpl_pkg::KIND_NUM : cpl_pkg::KIND_PUNCT;
               out.res0.punct_code = held_code_in;
               out.res0.token_first = held_first_in;
               out.res0.token_last = 1'b1;
            end else begin
               out.valid1 = 1'b1;
               out.res1.text_byte = held_char_in;
               out.res1.token_kind = (mode_in == cpl_pkg::M_IDENT) ? cpl_pkg::KIND_IDENT :
                  (mode_in >= cpl_pkg::M_ZERO && mode_in <= cpl_pkg::M_SUFFIX) ?
                  cpl_pkg::KIND_NUM : cpl_pkg::KIND_PUNCT;
               out.res1.punct_code = held_code_in;
               out.res1.token_first = held_first_in;
               out.res1.token_last = 1'b1;
            end
         end
         mode_in = cpl_pkg::M_IDLE;
         held_char_in = 8'd0; held_valid_in = 1'b0; quote_in = 1'b0;
         held_first_in = 1'b0; held_code_in = 9'd0;
      end
      // run and source marks on the last result
      if (out.valid1) begin
         out.res1.run_last = 1'b1;
         out.res1.source_done = stop;
      end else if (out.valid0) begin
         out.res0.run_last = 1'b1;
         out.res0.source_done = stop;
      end
   end

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cpl_pkg::M_IDLE;
         held_char_ff <= 8'd0;
         held_valid_ff <= 1'b0;
         quote_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_code_ff <= 9'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         held_char_ff <= held_char_in;
         held_valid_ff <= held_valid_in;
         quote_ff <= quote_in;
         held_first_ff <= held_first_in;
         held_code_ff <= held_code_in;
      end
   end

endmodule

// ===== sv/cpl_back.sv =====
`timescale 1ns / 1ps
module cpl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpl_pkg::pair_type   in,
   output logic                full,
   output logic                empty,
   input  logic                pop,
   output cpl_pkg::result_type head
);

   // four-entry result queue, up to two writes per cycle
   cpl_pkg::result_type mem_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff;
   logic       do_pop;
   logic [1:0] nwr;

   assign empty = (cnt_ff == 3'd0);
   assign full = (cnt_ff > 3'd2);
   assign head = mem_ff[rd_ff];
   assign do_pop = pop && !empty;
   assign nwr = push ? ({1'b0, in.valid0} + {1'b0, in.valid1}) : 2'd0;

   // queue storage
   always_ff @(posedge clock) begin
      if (push && in.valid0) mem_ff[wr_ff] <= in.res0;
      if (push && in.valid1) mem_ff[wr_ff + 2'd1] <= in.res1;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 2'd0;
         wr_ff <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff <= wr_ff + nwr;
         if (do_pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {1'b0, nwr} - {2'b0, do_pop};
      end
   end

endmodule

// ===== sv/c_preprocessor_lexer.sv =====
`timescale 1ns / 1ps
// C preprocessing tokenizer, one source byte per transaction.
// Input: push a byte on req_source_byte with req_source_end on the final
// byte; a transaction completes when push is high and full is low.
// Output: a queue of token bytes; while empty is low, rsp_* show the oldest
// result and pop takes it. Each result carries token kind, punctuator code,
// first/last marks, run_last and source_done.
// Whitespace and comments give no result; a byte gives up to two results.
// One byte is held back as lookahead, so a token byte appears once the
// following byte arrives or the source ends.
// Throughput: one byte per cycle while full is low, set by the combinational
// classifier in front; results appear in the cycle after the byte is taken
// and drain at one per cycle through a four-entry queue.
// full rises while more than two results wait; the byte taken just before
// can add two more, so a stalled receiver sees at most four queued results.
// Reset clears the lexer state and empties the queue.
module c_preprocessor_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_source_byte,
   input  logic       req_source_end,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_text_byte,
   output logic [2:0] rsp_token_kind,
   output logic [8:0] rsp_punct_code,
   output logic       rsp_token_first,
   output logic       rsp_token_last,
   output logic       rsp_run_last,
   output logic       rsp_source_done
);

   cpl_pkg::pair_type   pair;
   cpl_pkg::result_type head;
   logic                take;

   assign take = push && !full;

   cpl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .c       (req_source_byte),
      .src_end (req_source_end),
      .out     (pair)
   );

   cpl_back u_back (
      .clock (clock),
      .reset (reset),
      .push  (take),
      .in    (pair),
      .full  (full),
      .empty (empty),
      .pop   (pop),
      .head  (head)
   );

   assign rsp_text_byte   = head.text_byte;
   assign rsp_token_kind  = head.token_kind;
   assign rsp_punct_code  = head.punct_code;
   assign rsp_token_first = head.token_first;
   assign rsp_token_last  = head.token_last;
   assign rsp_run_last    = head.run_last;
   assign rsp_source_done = head.source_done;

endmodule
